[design/pngunf_pkg.sv]
// Shared types, constants and the Paeth predictor for the PNG scanline unfilter.
// No dependencies; used by png_scanline_unfilter_unit.
`default_nettype none

package pngunf_pkg;

    localparam int MAX_ROW_BYTES_DEF       = 8192;
    localparam int MAX_BYTES_PER_PIXEL_DEF = 4;

    localparam int ROW_BYTES_W  = 14;
    localparam int BPP_W        = 3;
    localparam int IMAGE_ROWS_W = 16;
    localparam int CFG_DATA_W   = 16;
    localparam int CFG_INDEX_W  = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ROW_BYTES       = 2'd0,
        CFG_BYTES_PER_PIXEL = 2'd1,
        CFG_IMAGE_ROWS      = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        FLT_NONE    = 3'd0,
        FLT_SUB     = 3'd1,
        FLT_UP      = 3'd2,
        FLT_AVERAGE = 3'd3,
        FLT_PAETH   = 3'd4
    } t_filter;

    // highest legal filter type byte
    localparam logic [7:0] FILTER_LIMIT = 8'd4;

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [9:0] sa;
        logic signed [9:0] sb;
        logic signed [9:0] sc;
        logic signed [9:0] da;
        logic signed [9:0] db;
        logic signed [9:0] dc;
        logic [9:0]        pa;
        logic [9:0]        pb;
        logic [9:0]        pc;
        logic [7:0]        pick;
        sa = signed'({2'b00, a});
        sb = signed'({2'b00, b});
        sc = signed'({2'b00, c});
        // p - a = b - c, p - b = a - c, p - c = a + b - 2c
        da = sb - sc;
        db = sa - sc;
        dc = sa + sb - sc - sc;
        pa = (da < 0) ? 10'(-da) : 10'(da);
        pb = (db < 0) ? 10'(-db) : 10'(db);
        pc = (dc < 0) ? 10'(-dc) : 10'(dc);
        if (pa <= pb && pa <= pc) begin
            pick = a;
        end else if (pb <= pc) begin
            pick = b;
        end else begin
            pick = c;
        end
        return pick;
    endfunction

endpackage

`default_nettype wire

[design/pngunf_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies; holds the previous scanline for the unfilter unit.
`default_nettype none

module pngunf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[design/png_scanline_unfilter_unit.sv]
// PNG scanline unfilter: top level with row/column control, predictor and output register.
// Depends on pngunf_pkg and pngunf_ram (previous-row line store).
`default_nettype none

// Takes one byte of the decompressed scanline stream per cycle and rebuilds each row under
// the None, Sub, Up, Average or Paeth filter. The first byte of a row is its filter type and
// yields no result; each data byte yields one result via the second-stage and output registers. A new
// byte is accepted every cycle while the output is drained, since the column and row counters
// are resolved on entry and the left-neighbor history sits next to the predictor in the second
// stage. The previous row lives in a one-read one-write RAM of MAX_ROW_BYTES bytes: the up byte
// is read on entry, the rebuilt byte is written back in the second stage. A filter type above
// 4 gives one result with o_bad_filter set, after which bytes are dropped until i_image_start.
// Configuration registers may only be written while no item is in flight.
module png_scanline_unfilter_unit #(
    parameter int MAX_ROW_BYTES       = pngunf_pkg::MAX_ROW_BYTES_DEF,
    parameter int MAX_BYTES_PER_PIXEL = pngunf_pkg::MAX_BYTES_PER_PIXEL_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [pngunf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [pngunf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [7:0]                        i_scan_byte,
    input  wire logic                              i_image_start,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic      [7:0]                        o_pixel_byte,
    output logic                                   o_row_end,
    output logic                                   o_image_end,
    output logic                                   o_bad_filter
);

    localparam int CW  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int LW  = $clog2(MAX_ROW_BYTES + 1);
    localparam int RW  = (pngunf_pkg::ROW_BYTES_W > LW) ? pngunf_pkg::ROW_BYTES_W : LW;
    localparam int BW  = $clog2(MAX_BYTES_PER_PIXEL + 1);
    localparam int BRW = (pngunf_pkg::BPP_W > BW) ? pngunf_pkg::BPP_W : BW;
    localparam int IW  = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;
    localparam int KW  = (CW > BW) ? CW : BW;
    localparam int HW  = 8 * MAX_BYTES_PER_PIXEL;
    localparam int YW  = pngunf_pkg::IMAGE_ROWS_W;

    typedef struct packed {
        logic [7:0]          data;
        pngunf_pkg::t_filter ftype;
        logic [CW-1:0]       col;
        logic [IW-1:0]       bidx;
        logic                left_ok;
        logic                row0;
        logic                rend;
        logic                iend;
        logic                bad;
    } t_s1;

    // configuration
    logic [pngunf_pkg::ROW_BYTES_W-1:0] r_row_bytes;
    logic [pngunf_pkg::BPP_W-1:0]       r_bpp;
    logic [YW-1:0]                      r_image_rows;

    // entry-side control
    logic [CW-1:0]       r_col, n_col;
    logic [YW-1:0]       r_row, n_row;
    logic                r_expf, n_expf;
    logic                r_drop, n_drop;
    pngunf_pkg::t_filter r_ftype, n_ftype;

    // second stage and output
    logic  r_s1_valid, n_s1_valid;
    t_s1   r_s1, n_s1;
    logic  r_out_valid;
    logic [HW-1:0] r_left_hist;
    logic [HW-1:0] r_ul_hist;

    logic          out_adv, s1_adv, accept, push, rd_en;
    logic          drop_e, expf_e;
    logic [YW-1:0] row_e;
    logic [RW-1:0] rb_ext;
    logic [LW-1:0] len_e, col_p1;
    logic [BRW-1:0] bpp_ext;
    logic [BW-1:0] bpp_e;
    logic [YW-1:0] rows_e;
    logic [YW:0]   row_p1;
    logic          rend, iend;
    logic [7:0]    up_rd;
    logic [7:0]    left_b, up_b, ul_b, pred, value;
    logic [8:0]    avg_sum;

    assign out_adv = !r_out_valid || !i_stall;
    assign s1_adv  = r_s1_valid && out_adv;
    assign o_stall = r_s1_valid && !out_adv;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;

    // clamp configuration to its legal range
    always_comb begin
        rb_ext = RW'(r_row_bytes);
        if (rb_ext == '0) begin
            len_e = LW'(1);
        end else if (rb_ext > RW'(MAX_ROW_BYTES)) begin
            len_e = LW'(MAX_ROW_BYTES);
        end else begin
            len_e = LW'(rb_ext);
        end
        bpp_ext = BRW'(r_bpp);
        if (bpp_ext == '0) begin
            bpp_e = BW'(1);
        end else if (bpp_ext > BRW'(MAX_BYTES_PER_PIXEL)) begin
            bpp_e = BW'(MAX_BYTES_PER_PIXEL);
        end else begin
            bpp_e = BW'(bpp_ext);
        end
        rows_e = (r_image_rows == '0) ? YW'(1) : r_image_rows;
    end

    // entry stage: resolve the byte's role and advance column and row
    always_comb begin
        drop_e = i_image_start ? 1'b0 : r_drop;
        expf_e = i_image_start ? 1'b1 : r_expf;
        row_e  = i_image_start ? '0 : r_row;
        col_p1 = LW'(r_col) + LW'(1);
        row_p1 = {1'b0, row_e} + (YW+1)'(1);
        rend   = col_p1 >= len_e;
        iend   = rend && (row_p1 >= {1'b0, rows_e});

        n_col   = r_col;
        n_row   = r_row;
        n_expf  = r_expf;
        n_drop  = r_drop;
        n_ftype = r_ftype;
        push    = 1'b0;
        rd_en   = 1'b0;

        n_s1.data    = i_scan_byte;
        n_s1.ftype   = r_ftype;
        n_s1.col     = r_col;
        n_s1.bidx    = IW'(bpp_e - BW'(1));
        n_s1.left_ok = KW'(r_col) >= KW'(bpp_e);
        n_s1.row0    = (row_e == '0);
        n_s1.rend    = rend;
        n_s1.iend    = iend;
        n_s1.bad     = 1'b0;

        if (accept) begin
            n_drop = drop_e;
            n_expf = expf_e;
            n_row  = row_e;
            if (!drop_e) begin
                if (expf_e) begin
                    n_col = '0;
                    if (i_scan_byte > pngunf_pkg::FILTER_LIMIT) begin
                        n_drop   = 1'b1;
                        push     = 1'b1;
                        n_s1.bad = 1'b1;
                    end else begin
                        n_ftype = pngunf_pkg::t_filter'(i_scan_byte[2:0]);
                        n_expf  = 1'b0;
                    end
                end else begin
                    push  = 1'b1;
                    rd_en = 1'b1;
                    if (rend) begin
                        n_expf = 1'b1;
                        n_col  = '0;
                        n_row  = iend ? '0 : row_p1[YW-1:0];
                    end else begin
                        n_col = col_p1[CW-1:0];
                    end
                end
            end
        end

        if (push) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end
    end

    pngunf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_ROW_BYTES)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (s1_adv && !r_s1.bad),
        .i_waddr (r_s1.col),
        .i_wdata (value),
        .i_re    (rd_en),
        .i_raddr (r_col),
        .o_rdata (up_rd)
    );

    // second stage: predictor
    always_comb begin
        left_b  = r_s1.left_ok ? r_left_hist[8*r_s1.bidx +: 8] : 8'd0;
        up_b    = r_s1.row0 ? 8'd0 : up_rd;
        ul_b    = (r_s1.row0 || !r_s1.left_ok) ? 8'd0 : r_ul_hist[8*r_s1.bidx +: 8];
        avg_sum = {1'b0, left_b} + {1'b0, up_b};
        case (r_s1.ftype)
            pngunf_pkg::FLT_SUB:     pred = left_b;
            pngunf_pkg::FLT_UP:      pred = up_b;
            pngunf_pkg::FLT_AVERAGE: pred = avg_sum[8:1];
            pngunf_pkg::FLT_PAETH:   pred = pngunf_pkg::paeth_pick(left_b, up_b, ul_b);
            default:                 pred = 8'd0;
        endcase
        value = r_s1.data + pred;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes  <= pngunf_pkg::ROW_BYTES_W'(1);
            r_bpp        <= pngunf_pkg::BPP_W'(1);
            r_image_rows <= YW'(1);
            r_col        <= '0;
            r_row        <= '0;
            r_expf       <= 1'b1;
            r_drop       <= 1'b0;
            r_ftype      <= pngunf_pkg::FLT_NONE;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (pngunf_pkg::t_cfg_index'(i_cfg_index))
                    pngunf_pkg::CFG_ROW_BYTES:
                        r_row_bytes <= i_cfg_data[pngunf_pkg::ROW_BYTES_W-1:0];
                    pngunf_pkg::CFG_BYTES_PER_PIXEL:
                        r_bpp <= i_cfg_data[pngunf_pkg::BPP_W-1:0];
                    pngunf_pkg::CFG_IMAGE_ROWS:
                        r_image_rows <= i_cfg_data[YW-1:0];
                    default: ;
                endcase
            end
            r_col      <= n_col;
            r_row      <= n_row;
            r_expf     <= n_expf;
            r_drop     <= n_drop;
            r_ftype    <= n_ftype;
            r_s1_valid <= n_s1_valid;
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            if (r_s1.bad) begin
                o_pixel_byte <= 8'd0;
                o_row_end    <= 1'b0;
                o_image_end  <= 1'b0;
                o_bad_filter <= 1'b1;
            end else begin
                o_pixel_byte <= value;
                o_row_end    <= r_s1.rend;
                o_image_end  <= r_s1.iend;
                o_bad_filter <= 1'b0;
                // shift in the rebuilt byte and its up byte
                r_left_hist  <= {r_left_hist[HW-9:0], value};
                r_ul_hist    <= {r_ul_hist[HW-9:0], up_b};
            end
        end
    end

    a_bad_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_filter) |-> (!o_row_end && !o_image_end && o_pixel_byte == 8'd0))
        else $error("bad filter result carries data");

    a_image_end_on_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_image_end) |-> o_row_end)
        else $error("image end without row end");

    a_no_same_entry_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd_en && s1_adv && !r_s1.bad) |-> (r_col != r_s1.col))
        else $error("line store read and write hit the same entry");

    a_stage_held_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && i_stall) |=> (r_s1_valid && $stable(r_s1)))
        else $error("second stage lost an item under stall");

    a_drop_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_drop && !i_image_start) |-> !push)
        else $error("item produced while dropping");

endmodule

`default_nettype wire

[verif/png_scanline_unfilter_unit_tb.sv]
// Self-checking testbench for png_scanline_unfilter_unit: directed and random scanline streams,
// each accepted byte fed to an in-bench unfilter model and its results checked in order.
// Depends on pngunf_pkg and png_scanline_unfilter_unit.
module png_scanline_unfilter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_BYTES    = pngunf_pkg::MAX_ROW_BYTES_DEF;
    localparam int MAX_BPP       = pngunf_pkg::MAX_BYTES_PER_PIXEL_DEF;
    localparam int CFG_IW        = pngunf_pkg::CFG_INDEX_W;
    localparam int CFG_DW        = pngunf_pkg::CFG_DATA_W;
    localparam int ROW_BW        = pngunf_pkg::ROW_BYTES_W;
    localparam int PIX_BW        = pngunf_pkg::BPP_W;
    localparam int ROWS_BW       = pngunf_pkg::IMAGE_ROWS_W;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 220;

    typedef struct packed {
        logic [7:0] pixel;
        logic       row_end;
        logic       image_end;
        logic       bad_filter;
    } t_pixel_result;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [CFG_IW-1:0]      i_cfg_index   = pngunf_pkg::CFG_ROW_BYTES;
    logic [CFG_DW-1:0]      i_cfg_data    = '0;
    logic                   i_valid       = 1'b0;
    logic                   o_stall;
    logic [7:0]             i_scan_byte   = '0;
    logic                   i_image_start = 1'b0;
    logic                   o_valid;
    logic                   i_stall       = 1'b0;
    logic [7:0]             o_pixel_byte;
    logic                   o_row_end;
    logic                   o_image_end;
    logic                   o_bad_filter;

    // unfilter model state
    logic [7:0]             line_mem [LINE_BYTES];
    logic [8*MAX_BPP-1:0]   left_bytes;
    logic [8*MAX_BPP-1:0]   up_left_bytes;
    int unsigned            col_pos;
    int unsigned            row_pos;
    logic                   want_filter;
    logic                   dropping;
    pngunf_pkg::t_filter    row_filter;
    logic [ROW_BW-1:0]      reg_row_bytes;
    logic [PIX_BW-1:0]      reg_bpp;
    logic [ROWS_BW-1:0]     reg_rows;

    t_pixel_result pending_pixels[$];
    t_pixel_result got;
    t_pixel_result want;
    int            errors        = 0;
    int unsigned   items_sent    = 0;
    int unsigned   cycle_count   = 0;
    bit            source_idling = 1'b1;
    bit            sink_idling   = 1'b1;
    int            hold_off_req  = 0;

    png_scanline_unfilter_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_scan_byte   (i_scan_byte),
        .i_image_start (i_image_start),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_byte  (o_pixel_byte),
        .o_row_end     (o_row_end),
        .o_image_end   (o_image_end),
        .o_bad_filter  (o_bad_filter)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned eff_row_len();
        int unsigned n;
        n = (reg_row_bytes == 0) ? 1 : reg_row_bytes;
        return (n > LINE_BYTES) ? LINE_BYTES : n;
    endfunction

    function automatic int unsigned eff_bpp();
        int unsigned n;
        n = (reg_bpp == 0) ? 1 : reg_bpp;
        return (n > MAX_BPP) ? MAX_BPP : n;
    endfunction

    function automatic int unsigned eff_rows();
        return (reg_rows == 0) ? 1 : reg_rows;
    endfunction

    function automatic int unsigned paeth_choose(input int a, input int b, input int c);
        int p;
        int pa;
        int pb;
        int pc;
        p  = a + b - c;
        pa = (p > a) ? p - a : a - p;
        pb = (p > b) ? p - b : b - p;
        pc = (p > c) ? p - c : c - p;
        if (pa <= pb && pa <= pc) return a;
        return (pb <= pc) ? b : c;
    endfunction

    function automatic void reset_model();
        left_bytes    = '0;
        up_left_bytes = '0;
        col_pos       = 0;
        row_pos       = 0;
        want_filter   = 1'b1;
        dropping      = 1'b0;
        row_filter    = pngunf_pkg::FLT_NONE;
        reg_row_bytes = 1;
        reg_bpp       = 1;
        reg_rows      = 1;
    endfunction

    // Advance the model by one accepted byte and queue the pixel it produces, if any.
    function automatic void unfilter_byte(input logic [7:0] b, input logic st);
        int unsigned len;
        int unsigned bpp;
        int unsigned col;
        int unsigned left;
        int unsigned up;
        int unsigned ul;
        int unsigned pred;
        logic [7:0]  value;
        logic        rend;
        logic        iend;
        if (st) begin
            dropping    = 1'b0;
            want_filter = 1'b1;
            row_pos     = 0;
        end
        if (dropping) return;
        if (want_filter) begin
            col_pos       = 0;
            left_bytes    = '0;
            up_left_bytes = '0;
            if (b > pngunf_pkg::FILTER_LIMIT) begin
                dropping = 1'b1;
                pending_pixels.push_back('{8'h00, 1'b0, 1'b0, 1'b1});
                return;
            end
            row_filter  = pngunf_pkg::t_filter'(b[2:0]);
            want_filter = 1'b0;
            return;
        end
        len  = eff_row_len();
        bpp  = eff_bpp();
        col  = col_pos;
        left = (col >= bpp) ? left_bytes[8*(bpp-1) +: 8] : 0;
        up   = (row_pos == 0) ? 0 : line_mem[col];
        ul   = (row_pos == 0 || col < bpp) ? 0 : up_left_bytes[8*(bpp-1) +: 8];
        case (row_filter)
            pngunf_pkg::FLT_SUB:     pred = left;
            pngunf_pkg::FLT_UP:      pred = up;
            pngunf_pkg::FLT_AVERAGE: pred = (left + up) >> 1;
            pngunf_pkg::FLT_PAETH:   pred = paeth_choose(left, up, ul);
            default:                 pred = 0;
        endcase
        value         = 8'(b + pred);
        line_mem[col] = value;
        left_bytes    = {left_bytes[8*MAX_BPP-9:0], value};
        up_left_bytes = {up_left_bytes[8*MAX_BPP-9:0], 8'(up)};
        rend = (col + 1 >= len);
        iend = rend && (row_pos + 1 >= eff_rows());
        if (rend) begin
            want_filter = 1'b1;
            col_pos     = 0;
            row_pos     = iend ? 0 : ((row_pos + 1) & 16'hFFFF);
        end else begin
            col_pos = col + 1;
        end
        pending_pixels.push_back('{value, rend, iend, 1'b0});
    endfunction

    // Mostly no gap, some short ones, a few long ones.
    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(99);
        if (r < 70) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] data_byte();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] any_filter();
        return 8'($urandom_range(pngunf_pkg::FLT_NONE, pngunf_pkg::FLT_PAETH));
    endfunction

    task automatic send_item(input logic [7:0] b, input logic st);
        int gap;
        gap = pick_gap(source_idling);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_scan_byte   <= b;
        i_image_start <= st;
        do @(posedge i_clk); while (o_stall);
        unfilter_byte(b, st);
        items_sent++;
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        // a trailing filter byte gives no result but may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input pngunf_pkg::t_cfg_index idx, input logic [CFG_DW-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            pngunf_pkg::CFG_ROW_BYTES:       reg_row_bytes = data[ROW_BW-1:0];
            pngunf_pkg::CFG_BYTES_PER_PIXEL: reg_bpp       = data[PIX_BW-1:0];
            pngunf_pkg::CFG_IMAGE_ROWS:      reg_rows      = data[ROWS_BW-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CFG_DW-1:0] rb, input logic [CFG_DW-1:0] bpp,
                             input logic [CFG_DW-1:0] rows);
        wait_for_results();
        write_reg(pngunf_pkg::CFG_ROW_BYTES, rb);
        write_reg(pngunf_pkg::CFG_BYTES_PER_PIXEL, bpp);
        write_reg(pngunf_pkg::CFG_IMAGE_ROWS, rows);
        i_cfg_wr_en <= 1'b0;
    endtask

    // One image under the current settings; noisy adds bad filters and abandoned rows.
    task automatic send_image(input logic first_start, input bit noisy);
        int unsigned len;
        int unsigned rows;
        logic [7:0]  flt;
        len  = eff_row_len();
        rows = eff_rows();
        for (int unsigned r = 0; r < rows; r++) begin
            flt = any_filter();
            if (noisy && $urandom_range(99) < 4) begin
                flt = 8'($urandom_range(pngunf_pkg::FILTER_LIMIT + 1, 255));
            end
            send_item(flt, (r == 0) ? first_start : 1'b0);
            if (flt > pngunf_pkg::FILTER_LIMIT) begin
                repeat ($urandom_range(0, 4)) send_item(data_byte(), 1'b0);
                return;
            end
            for (int unsigned c = 0; c < len; c++) begin
                if (noisy && $urandom_range(199) == 0) begin
                    send_item(any_filter(), 1'b1);
                    return;
                end
                send_item(data_byte(), 1'b0);
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_item(8'(pngunf_pkg::FLT_NONE), 1'b1);
        send_item(8'h5A, 1'b0);
        // stream after the last row opens a new image without a start flag
        send_item(8'(pngunf_pkg::FLT_SUB), 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'(pngunf_pkg::FLT_PAETH), 1'b1);
        send_item(8'h00, 1'b0);
    endtask

    task automatic test_filter_types();
        configure(4, 2, 5);
        send_item(8'(pngunf_pkg::FLT_NONE), 1'b1);
        send_item(8'hFF, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'h80, 1'b0);
        send_item(8'h7F, 1'b0);
        send_item(8'(pngunf_pkg::FLT_SUB), 1'b0);
        repeat (4) send_item(data_byte(), 1'b0);
        send_item(8'(pngunf_pkg::FLT_UP), 1'b0);
        repeat (4) send_item(data_byte(), 1'b0);
        send_item(8'(pngunf_pkg::FLT_AVERAGE), 1'b0);
        repeat (4) send_item(8'hFF, 1'b0);
        send_item(8'(pngunf_pkg::FLT_PAETH), 1'b0);
        repeat (4) send_item(data_byte(), 1'b0);
    endtask

    task automatic test_bad_filter();
        configure(2, 1, 3);
        send_item(pngunf_pkg::FILTER_LIMIT + 8'd1, 1'b1);
        send_item(8'hAA, 1'b0);
        send_item(8'(pngunf_pkg::FLT_NONE), 1'b0);
        send_item(8'(pngunf_pkg::FLT_SUB), 1'b1);
        send_item(8'h12, 1'b0);
        send_item(8'hF0, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'h11, 1'b0);
        send_item(8'(pngunf_pkg::FLT_UP), 1'b1);
        send_item(8'h34, 1'b0);
        send_item(8'h56, 1'b0);
    endtask

    task automatic test_special_cases();
        // image start in mid-row abandons the row
        configure(4, 2, 2);
        send_item(8'(pngunf_pkg::FLT_SUB), 1'b1);
        send_item(8'h21, 1'b0);
        send_item(8'h43, 1'b0);
        send_item(8'(pngunf_pkg::FLT_PAETH), 1'b1);
        repeat (4) send_item(data_byte(), 1'b0);
        send_item(8'(pngunf_pkg::FLT_UP), 1'b0);
        repeat (4) send_item(data_byte(), 1'b0);

        // zero settings behave as one
        configure(0, 0, 0);
        send_item(8'(pngunf_pkg::FLT_SUB), 1'b1);
        send_item(8'h99, 1'b0);
        send_item(8'(pngunf_pkg::FLT_AVERAGE), 1'b0);
        send_item(8'h01, 1'b0);

        // oversized pixel size clamps to the pixel limit
        source_idling = 1'b0;
        sink_idling   = 1'b0;
        configure(6, 16'hFFFF, 2);
        send_image(1'b1, 1'b0);
        source_idling = 1'b1;
        sink_idling   = 1'b1;

        // shrink the row while idle mid-row: the next byte ends it
        configure(8, 3, 3);
        send_item(8'(pngunf_pkg::FLT_AVERAGE), 1'b1);
        repeat (4) send_item(data_byte(), 1'b0);
        configure(3, 5, 3);
        send_item(data_byte(), 1'b0);
        send_item(8'(pngunf_pkg::FLT_PAETH), 1'b0);
        repeat (3) send_item(data_byte(), 1'b0);
        send_item(8'(pngunf_pkg::FLT_UP), 1'b0);
        repeat (3) send_item(data_byte(), 1'b0);

        // tall image that never finishes before the next start
        configure(1, 4, 16'hFFFF);
        send_item(8'(pngunf_pkg::FLT_NONE), 1'b1);
        send_item(data_byte(), 1'b0);
        repeat (40) begin
            send_item(any_filter(), 1'b0);
            send_item(data_byte(), 1'b0);
        end
        send_item(8'(pngunf_pkg::FLT_UP), 1'b1);
        send_item(data_byte(), 1'b0);
    endtask

    task automatic test_backpressure();
        configure(12, 3, 4);
        source_idling = 1'b0;
        hold_off_req  = 300;
        send_image(1'b1, 1'b0);
        source_idling = 1'b1;
        // hold the source until the output drains completely
        wait_for_results();
        send_image(1'b1, 1'b1);
    endtask

    task automatic test_random_stream();
        int unsigned       base;
        int                r;
        logic [CFG_DW-1:0] rb;
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            if (r < 85) rb = CFG_DW'($urandom_range(0, 20));
            else if (r < 97) rb = CFG_DW'($urandom_range(21, 64));
            else rb = CFG_DW'($urandom_range(65, 128));
            configure(rb, CFG_DW'($urandom_range(0, 7)), CFG_DW'($urandom_range(0, 5)));
            source_idling = ($urandom_range(3) != 0);
            sink_idling   = ($urandom_range(3) != 0);
            // first image of a phase always starts cleanly
            send_image(1'b1, 1'b1);
            repeat ($urandom_range(0, 3)) send_image($urandom_range(99) < 85, 1'b1);
        end
        source_idling = 1'b1;
        sink_idling   = 1'b1;
    endtask

    task automatic finish_run();
        int waited;
        i_valid <= 1'b0;
        waited = 0;
        while (pending_pixels.size() != 0 && waited < 10000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (20) @(posedge i_clk);
        if (pending_pixels.size() != 0) begin
            $display("%0t: %0d expected pixel results never arrived", $time,
                     pending_pixels.size());
            errors++;
        end
        if (errors == 0) begin
            $display("png_scanline_unfilter_unit_tb: clean");
        end else begin
            $display("png_scanline_unfilter_unit_tb: errors");
        end
        $finish;
    endtask

    initial begin
        reset_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_filter_types();
        test_bad_filter();
        test_special_cases();
        test_backpressure();
        test_random_stream();
        finish_run();
    end

    // output side: random stalls, plus a long hold-off on request
    initial begin
        int run;
        run = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req > 0) begin
                run          = hold_off_req;
                hold_off_req = 0;
            end
            if (run > 0) begin
                i_stall <= 1'b1;
                run--;
            end else if (!sink_idling) begin
                i_stall <= 1'b0;
            end else begin
                run = pick_gap(1'b1);
                i_stall <= (run > 0);
                if (run > 0) run--;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_pixel_byte, o_row_end, o_image_end, o_bad_filter};
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel=%02h row_end=%b image_end=%b bad_filter=%b",
                         $time, got.pixel, got.row_end, got.image_end, got.bad_filter);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected pixel=%02h row_end=%b image_end=%b %s%b",
                             $time, want.pixel, want.row_end, want.image_end, "bad_filter=",
                             want.bad_filter);
                    $display("%0t:          actual   pixel=%02h row_end=%b image_end=%b %s%b",
                             $time, got.pixel, got.row_end, got.image_end, "bad_filter=",
                             got.bad_filter);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("png_scanline_unfilter_unit_tb: errors");
            $finish;
        end
    end

endmodule
